@@ hdl/tmf_pkg.sv @@
`timescale 1ns / 1ps
package tmf_pkg;

  // fixed point formats of the conversion path
  localparam int Q_BITS        = 30;
  localparam int FIX_W         = 31;
  localparam int LOG_FRAC_BITS = 16;
  localparam int STEP_W        = 4;
  localparam int RAW_W         = 17;
  localparam int DIST_W        = 16;
  localparam int OFFSET_W      = 15;
  localparam int IP_W          = 5;
  localparam int TOO_LARGE_IP  = 17;

  // log2(5), log2(27726) and the exponent 1.2045, all in q16
  localparam int     LOG2_5_Q16 = 152170;
  localparam longint LOG2_K_Q16 = 967243;
  localparam int     EXPO_Q16   = 78938;
  localparam int     EXPO_W     = 18;

  typedef struct packed {
    logic insert;
    logic drop;
  } win_cmd_t;

  typedef struct packed {
    logic valid;
    logic take;
  } cell_flags_t;

  typedef struct packed {
    logic             too_large;
    logic [RAW_W-1:0] raw;
  } conv_res_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w > rem) begin
        bit_w = bit_w >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_w != '0) begin
        if (rem >= res + bit_w) begin
          rem = rem - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in q30, each root taken from the one before it
  function automatic logic [FIX_W-1:0] exp_root(int k);
    logic [63:0] c;
    c = 64'd2 << Q_BITS;
    for (int j = 1; j <= k; j++) begin
      c = isqrt64(c << Q_BITS);
    end
    return c[FIX_W-1:0];
  endfunction

  localparam logic [FIX_W-1:0] EXP_ROOT [LOG_FRAC_BITS] = '{
    exp_root(1),  exp_root(2),  exp_root(3),  exp_root(4),
    exp_root(5),  exp_root(6),  exp_root(7),  exp_root(8),
    exp_root(9),  exp_root(10), exp_root(11), exp_root(12),
    exp_root(13), exp_root(14), exp_root(15), exp_root(16)
  };

endpackage

@@ hdl/tmf_if.sv @@
`timescale 1ns / 1ps
interface tmf_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_code;

  modport source (output valid, output sample_code, input ready);
  modport sink (input valid, input sample_code, output ready);
endinterface

interface tmf_result_if;
  logic                        valid;
  logic                        ready;
  logic [tmf_pkg::DIST_W-1:0]  distance;
  logic                        clamped;

  modport source (output valid, output distance, output clamped, input ready);
  modport sink (input valid, input distance, input clamped, output ready);
endinterface

@@ hdl/tmf_cell.sv @@
`timescale 1ns / 1ps
module tmf_cell #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmf_pkg::win_cmd_t      cmd_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  tmf_pkg::cell_flags_t   left_flags_i,
  input  logic [SAMPLE_BITS-1:0] left_value_i,
  input  logic                   right_valid_i,
  input  logic [SAMPLE_BITS-1:0] right_value_i,
  output tmf_pkg::cell_flags_t   flags_o,
  output logic [SAMPLE_BITS-1:0] value_o
);

  logic                   valid_q, valid_d;
  logic [SAMPLE_BITS-1:0] value_q, value_d;
  logic                   take;

  // new sample belongs here or further left
  assign take = !valid_q || (sample_i < value_q);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.drop) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (cmd_i.insert) begin
      if (left_flags_i.take) begin
        valid_d = left_flags_i.valid;
        value_d = left_value_i;
      end else if (take) begin
        valid_d = 1'b1;
        value_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign flags_o.valid = valid_q;
  assign flags_o.take  = take;
  assign value_o       = value_q;

endmodule

@@ hdl/tmf_window.sv @@
`timescale 1ns / 1ps
module tmf_window #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmf_pkg::win_cmd_t      cmd_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   last_o,
  output logic [SUM_W-1:0]       mid_sum_o
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [CNT_W-1:0]       count_q, count_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic [SUM_W-1:0]       mid_sum;
  logic [SAMPLE_BITS-1:0] value [WINDOW];
  tmf_pkg::cell_flags_t   flags [WINDOW];

  // sorted chain, smallest value in cell 0
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tmf_pkg::cell_flags_t   left_flags;
    logic [SAMPLE_BITS-1:0] left_value;
    logic                   right_valid;
    logic [SAMPLE_BITS-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_flags = '0;
      assign left_value = '0;
    end else begin : g_inner
      assign left_flags = flags[i-1];
      assign left_value = value[i-1];
    end

    // the two top cells empty on a drop: that removes the maximum
    if (i >= WINDOW - 2) begin : g_top
      assign right_valid = 1'b0;
      assign right_value = '0;
    end else begin : g_below
      assign right_valid = flags[i+1].valid;
      assign right_value = value[i+1];
    end

    tmf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .sample_i      (sample_i),
      .left_flags_i  (left_flags),
      .left_value_i  (left_value),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .flags_o       (flags[i]),
      .value_o       (value[i])
    );
  end

  assign mid_sum = total_q - SUM_W'(value[0]) - SUM_W'(value[WINDOW-1]);

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.drop) begin
      count_d = CNT_W'(WINDOW - 2);
      total_d = mid_sum;
    end else if (cmd_i.insert) begin
      count_d = count_q + 1'b1;
      total_d = total_q + SUM_W'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  assign last_o    = (count_q == CNT_W'(WINDOW - 1));
  assign mid_sum_o = mid_sum;

`ifndef SYNTH
  for (genvar i = 0; i < WINDOW - 1; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      flags[i+1].valid |-> value[i] <= value[i+1])
      else $error("window cells out of order");
    a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
      flags[i+1].valid |-> flags[i].valid)
      else $error("gap in window cells");
  end
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |-> count_q == CNT_W'(WINDOW) && !cmd_i.insert)
    else $error("drop on a window that is not full");
`endif

endmodule

@@ hdl/tmf_conv.sv @@
`timescale 1ns / 1ps
module tmf_conv #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] mean_i,
  output logic                   done_o,
  output tmf_pkg::conv_res_t     res_o
);

  localparam int NB     = $clog2(SAMPLE_BITS);
  localparam int L_W    = NB + tmf_pkg::LOG_FRAC_BITS;
  localparam int T_W    = L_W + 2;
  localparam int P_W    = T_W + tmf_pkg::EXPO_W;
  localparam int E_W    = P_W + 1;
  localparam int T_BIAS = tmf_pkg::LOG2_5_Q16 - SAMPLE_BITS * 65536;
  localparam longint K_SCALED = tmf_pkg::LOG2_K_Q16 * 65536;
  localparam int FW     = tmf_pkg::FIX_W;
  localparam int SW     = tmf_pkg::STEP_W;
  localparam int LFB    = tmf_pkg::LOG_FRAC_BITS;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_LOG  = 3'd1;
  localparam logic [2:0] C_TMUL = 3'd2;
  localparam logic [2:0] C_ESUB = 3'd3;
  localparam logic [2:0] C_EXP  = 3'd4;
  localparam logic [2:0] C_DONE = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [SW-1:0]                  step_q, step_d;
  logic [NB-1:0]                  n_q, n_d, n_enc;
  logic [LFB-1:0]                 frac_q, frac_d;
  logic [FW-1:0]                  acc_q, acc_d;
  logic signed [P_W-1:0]          prod_q, prod_d;
  logic [tmf_pkg::IP_W-1:0]       ip_q, ip_d;
  logic                           too_large_q, too_large_d;
  logic [FW-1:0]                  mul_b;
  logic [2*FW-1:0]                mul_full;
  logic [FW:0]                    sq;
  logic signed [T_W-1:0]          t;
  logic signed [E_W-1:0]          eq;
  logic [E_W-33:0]                ip_wide;

  // leading one of the mean code
  always_comb begin
    n_enc = '0;
    for (int i = 1; i < SAMPLE_BITS; i++) begin
      if (mean_i[i]) begin
        n_enc = NB'(i);
      end
    end
  end

  // one shared 31x31 multiplier: squaring for log2, root products for 2^f
  assign mul_b    = (state_q == C_EXP) ? tmf_pkg::EXP_ROOT[step_q] : acc_q;
  assign mul_full = (2*FW)'(acc_q) * (2*FW)'(mul_b);
  assign sq       = mul_full[2*FW-1:tmf_pkg::Q_BITS];

  assign t  = $signed({2'b00, n_q, frac_q}) + $signed(T_W'(T_BIAS));
  assign eq = $signed(E_W'(K_SCALED)) - $signed({prod_q[P_W-1], prod_q});
  assign ip_wide = eq[E_W-1:32];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    n_d         = n_q;
    frac_d      = frac_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    ip_d        = ip_q;
    too_large_d = too_large_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          n_d     = n_enc;
          acc_d   = FW'(mean_i) << (5'(tmf_pkg::Q_BITS) - 5'(n_enc));
          frac_d  = '0;
          step_d  = '0;
          state_d = C_LOG;
        end
      end
      C_LOG: begin
        if (sq[FW]) begin
          acc_d  = sq[FW:1];
          frac_d = {frac_q[LFB-2:0], 1'b1};
        end else begin
          acc_d  = sq[FW-1:0];
          frac_d = {frac_q[LFB-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == SW'(LFB - 1)) begin
          state_d = C_TMUL;
        end
      end
      C_TMUL: begin
        prod_d  = t * $signed(tmf_pkg::EXPO_W'(tmf_pkg::EXPO_Q16));
        state_d = C_ESUB;
      end
      C_ESUB: begin
        if (eq[E_W-1]) begin
          // negative exponent floors at zero
          too_large_d = 1'b0;
          ip_d        = '0;
          frac_d      = '0;
        end else begin
          too_large_d = (ip_wide >= (E_W-32)'(tmf_pkg::TOO_LARGE_IP));
          ip_d        = eq[32 +: tmf_pkg::IP_W];
          frac_d      = eq[16 +: LFB];
        end
        acc_d   = FW'(1) << tmf_pkg::Q_BITS;
        step_d  = '0;
        state_d = (!eq[E_W-1] && ip_wide >= (E_W-32)'(tmf_pkg::TOO_LARGE_IP))
                  ? C_DONE : C_EXP;
      end
      C_EXP: begin
        if (frac_q[LFB-1]) begin
          acc_d = sq[FW-1:0];
        end
        frac_d = {frac_q[LFB-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == SW'(LFB - 1)) begin
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    n_q         <= n_d;
    frac_q      <= frac_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    ip_q        <= ip_d;
    too_large_q <= too_large_d;
  end

  assign done_o          = (state_q == C_DONE);
  assign res_o.too_large = too_large_q;
  assign res_o.raw       = tmf_pkg::RAW_W'(acc_q >> (5'(tmf_pkg::Q_BITS) - ip_q));

endmodule

@@ hdl/trimmed_mean_ir_range_filter.sv @@
`timescale 1ns / 1ps
// a request that does not complete the window is taken and gives no result; one that
// completes it runs drop, multiply, correct and start, then the conversion, a 16-step log2
// and a 16-step 2^f loop on one shared multiplier (skipped for a zero mean code, the 2^f
// loop skipped when the distance is out of range); ready stays low meanwhile
// reset: asynchronous active low, clears the window to empty and the offset to zero
module trimmed_mean_ir_range_filter #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tmf_sample_if.sink                     sample_i,
  tmf_result_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [tmf_pkg::OFFSET_W-1:0]   cfg_wdata_i
);

  // trimmed mean divides by the count of middle values
  localparam int DIV     = WINDOW - 2;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int RECIP_S = SUM_W;
  localparam int RECIP   = (2 ** RECIP_S) / DIV;
  localparam int QP_W    = SUM_W + RECIP_S;
  localparam int CHK_W   = SUM_W + 1;
  localparam int S_W     = tmf_pkg::RAW_W + 2;
  localparam int DW      = tmf_pkg::DIST_W;

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_DROP  = 3'd1;
  localparam logic [2:0] T_MUL   = 3'd2;
  localparam logic [2:0] T_CORR  = 3'd3;
  localparam logic [2:0] T_START = 3'd4;
  localparam logic [2:0] T_WAIT  = 3'd5;
  localparam logic [2:0] T_FIN   = 3'd6;

  logic [2:0]                       state_q, state_d;
  logic [SUM_W-1:0]                 sum_q, sum_d;
  logic [QP_W-1:0]                  qprod_q, qprod_d;
  logic [SAMPLE_BITS-1:0]           mean_q, mean_d;
  tmf_pkg::conv_res_t               conv_q, conv_d;
  logic [tmf_pkg::OFFSET_W-1:0]     offset_q;
  logic                             out_valid_q, out_valid_d;
  logic [DW-1:0]                    out_dist_q, out_dist_d;
  logic                             out_clamp_q, out_clamp_d;

  tmf_pkg::win_cmd_t                win_cmd;
  logic                             win_last;
  logic [SUM_W-1:0]                 win_mid_sum;
  logic                             accept;
  logic                             conv_start;
  logic                             conv_done;
  tmf_pkg::conv_res_t               conv_res;
  logic [SAMPLE_BITS-1:0]           q_est;
  logic [SUM_W-1:0]                 q_rem;
  logic signed [S_W-1:0]            dist_sum;
  logic                             out_free;

  // requests are taken only while no window result is in flight
  assign sample_i.ready = (state_q == T_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;

  assign win_cmd.insert = accept;
  assign win_cmd.drop   = (state_q == T_DROP);

  // sorted window, keeps its sum so the middle sum needs two subtracts
  tmf_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (win_cmd),
    .sample_i  (sample_i.sample_code),
    .last_o    (win_last),
    .mid_sum_o (win_mid_sum)
  );

  // voltage code to distance: log2, scale by the exponent, then 2^x
  assign conv_start = (state_q == T_START) && (mean_q != '0);

  tmf_conv #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mean_i  (mean_q),
    .done_o  (conv_done),
    .res_o   (conv_res)
  );

  // floor division by a constant: reciprocal estimate is low by at most one
  assign q_est = SAMPLE_BITS'(qprod_q >> RECIP_S);
  assign q_rem = sum_q - SUM_W'(SUM_W'(q_est) * SUM_W'(DIV));

  // offset is sign extended and added to the raw distance
  assign dist_sum = $signed({2'b00, conv_q.raw})
                  + $signed({{(S_W - tmf_pkg::OFFSET_W){offset_q[tmf_pkg::OFFSET_W-1]}},
                             offset_q});

  // the output register frees up in the cycle its result is taken
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    qprod_d     = qprod_q;
    mean_d      = mean_q;
    conv_d      = conv_q;
    out_valid_d = out_valid_q;
    out_dist_d  = out_dist_q;
    out_clamp_d = out_clamp_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      T_IDLE: begin
        // the request that fills the last slot starts the reduction
        if (accept && win_last) begin
          state_d = T_DROP;
        end
      end
      T_DROP: begin
        // window drops its min and max as the middle sum is taken
        sum_d   = win_mid_sum;
        state_d = T_MUL;
      end
      T_MUL: begin
        qprod_d = QP_W'(sum_q) * QP_W'(RECIP);
        state_d = T_CORR;
      end
      T_CORR: begin
        mean_d  = (q_rem >= SUM_W'(DIV)) ? q_est + 1'b1 : q_est;
        state_d = T_START;
      end
      T_START: begin
        if (mean_q == '0) begin
          // zero volts reads as infinitely far
          conv_d.too_large = 1'b1;
          conv_d.raw       = '0;
          state_d          = T_FIN;
        end else begin
          state_d = T_WAIT;
        end
      end
      T_WAIT: begin
        if (conv_done) begin
          conv_d  = conv_res;
          state_d = T_FIN;
        end
      end
      T_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (conv_q.too_large) begin
            out_dist_d  = '1;
            out_clamp_d = 1'b1;
          end else if (dist_sum < 0) begin
            out_dist_d  = '0;
            out_clamp_d = 1'b1;
          end else if (dist_sum > $signed(S_W'({DW{1'b1}}))) begin
            out_dist_d  = '1;
            out_clamp_d = 1'b1;
          end else begin
            out_dist_d  = dist_sum[DW-1:0];
            out_clamp_d = 1'b0;
          end
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    qprod_q     <= qprod_d;
    mean_q      <= mean_d;
    conv_q      <= conv_d;
    out_dist_q  <= out_dist_d;
    out_clamp_q <= out_clamp_d;
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.distance = out_dist_q;
  assign result_o.clamped  = out_clamp_q;

`ifndef SYNTH
  a_mean_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_START |->
      CHK_W'(mean_q) * CHK_W'(DIV) <= CHK_W'(sum_q) &&
      CHK_W'(sum_q) < (CHK_W'(mean_q) + 1'b1) * CHK_W'(DIV))
    else $error("trimmed mean is not the floor quotient");
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == T_WAIT)
    else $error("conversion finished with no mean pending");
  a_clamp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.clamped |->
      result_o.distance == '0 || result_o.distance == '1)
    else $error("clamped distance not at a range end");
`endif

endmodule

@@ dv/tb_trimmed_mean_ir_range_filter.sv @@
`timescale 1ns / 1ps
module tb_trimmed_mean_ir_range_filter;

  localparam int WIN   = 8;
  localparam int SMP_W = 12;

  // conversion constants in q16: log2(5), log2(27726), exponent 1.2045
  localparam longint LOG2_FIVE = 152170;
  localparam longint LOG2_GAIN = 967243;
  localparam longint POWER     = 78938;
  localparam bit [63:0] ONE_Q30 = 64'd1 << 30;

  // bound on how long the slowest result takes after the request that completes the window
  localparam int RESULT_LATENCY = 40;
  localparam int SETTLE_CYCLES  = 60;
  localparam int STALL_LIMIT    = 3000;
  localparam int PHASE_ITEMS    = 145;

  typedef struct packed {
    logic [tmf_pkg::DIST_W-1:0] distance;
    logic                       clamped;
  } range_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tmf_pkg::OFFSET_W-1:0] cfg_wdata_i = '0;

  // local copies of the handshake drive, known from time zero
  logic             smp_valid = 1'b0;
  logic [SMP_W-1:0] smp_code = '0;
  logic             res_ready = 1'b0;

  tmf_sample_if #(.SAMPLE_BITS(SMP_W)) sample_if ();
  tmf_result_if                        result_if ();

  assign sample_if.valid       = smp_valid;
  assign sample_if.sample_code = smp_code;
  assign result_if.ready       = res_ready;

  trimmed_mean_ir_range_filter #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SMP_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  wire smp_fire = sample_if.valid & sample_if.ready;
  wire res_fire = result_if.valid & result_if.ready;

  // predictor state: sample window, fill position and the offset in force
  bit [SMP_W-1:0] win_slots [WIN];
  int             fill_ptr;
  int             range_offset;

  logic [SMP_W-1:0] pending_codes [$];
  range_res_t       expected_ranges [$];
  int               error_count;
  bit               phase_calm;
  int               drv_gap;
  bit               drv_busy;
  int               rdy_gap;
  int               idle_cycles;

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // log2 of the mean code in q16, truncated
  function automatic bit [31:0] log2_q16_of(bit [SMP_W-1:0] m);
    int        msb;
    bit [63:0] y;
    bit [15:0] frac;
    msb = 0;
    for (int b = 0; b < SMP_W; b++) begin
      if (m[b]) msb = b;
    end
    y = 64'(m) << (30 - msb);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = {frac[14:0], 1'b0};
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return {msb[15:0], frac};
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // mean code to distance in hundredths of a cm, offset added and saturated
  function automatic range_res_t mean_to_range(int unsigned mean, int offset);
    range_res_t res;
    longint     t;
    longint     eq;
    longint     e;
    longint     ip;
    longint     s;
    bit [15:0]  f;
    bit [63:0]  r;
    bit [63:0]  c;
    res.distance = 16'hFFFF;
    res.clamped  = 1'b1;
    // no voltage means infinite range
    if (mean == 0) return res;
    t  = longint'(log2_q16_of(mean[SMP_W-1:0])) + LOG2_FIVE - longint'(SMP_W) * 65536;
    eq = LOG2_GAIN * 65536 - t * POWER;
    if (eq < 0) eq = 0;
    e  = eq >>> 16;
    ip = e >>> 16;
    f  = e[15:0];
    if (ip >= 17) return res;
    r = ONE_Q30;
    c = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      c = floor_sqrt(c << 30);
      if (f[16-k]) r = (r * c) >> 30;
    end
    s = longint'(r >> (30 - ip)) + offset;
    if (s < 0) begin
      res.distance = '0;
    end else if (s <= 65535) begin
      res.distance = s[15:0];
      res.clamped  = 1'b0;
    end
    return res;
  endfunction

  // window update for one accepted request, queues a result when it completes
  task automatic take_sample(bit [SMP_W-1:0] code);
    int             p;
    int             j;
    bit [SMP_W-1:0] v;
    int unsigned    sum;
    p = fill_ptr;
    if (p >= WIN) p = WIN - 1;
    win_slots[p] = code;
    if (p < WIN - 1) begin
      fill_ptr = p + 1;
      return;
    end
    for (int i = 1; i < WIN; i++) begin
      v = win_slots[i];
      j = i - 1;
      while (j >= 0 && win_slots[j] > v) begin
        win_slots[j+1] = win_slots[j];
        j--;
      end
      win_slots[j+1] = v;
    end
    // drop the minimum, keep the middle ones low and the top two on top
    sum = 0;
    for (int i = 0; i < WIN - 2; i++) begin
      win_slots[i] = win_slots[i+1];
      sum += 32'(win_slots[i]);
    end
    fill_ptr = WIN - 2;
    expected_ranges.push_back(mean_to_range(sum / (WIN - 2), range_offset));
  endtask

  function automatic logic [SMP_W-1:0] rand_code();
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 40) return SMP_W'($urandom_range(0, 4095));
    // low codes: far ranges where saturation and the too large case live
    if (r < 65) return SMP_W'($urandom_range(0, 700));
    if (r < 90) begin
      c = 2048 + $urandom_range(0, 80) - 40;
      return c[SMP_W-1:0];
    end
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 12'd1;
      2: return 12'hFFE;
      default: return 12'hFFF;
    endcase
  endfunction

  // request driver, one item at a time from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_valid <= 1'b0;
      drv_busy  = 1'b0;
      drv_gap   = 0;
    end else begin
      if (smp_fire) begin
        take_sample(smp_code);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          smp_valid <= 1'b0;
        end else if (pending_codes.size() != 0) begin
          smp_code  <= pending_codes.pop_front();
          smp_valid <= 1'b1;
          drv_busy  = 1'b1;
          drv_gap   = phase_calm ? 0 : pick_gap();
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      rdy_gap   = 0;
    end else begin
      if (res_fire) begin
        if (expected_ranges.size() == 0) begin
          report_mismatch($sformatf("unexpected result distance %0d clamped %0b",
                                    result_if.distance, result_if.clamped));
        end else begin
          range_res_t exp_res;
          exp_res = expected_ranges.pop_front();
          if (result_if.distance !== exp_res.distance)
            report_mismatch($sformatf("distance got %0d expected %0d",
                                      result_if.distance, exp_res.distance));
          if (result_if.clamped !== exp_res.clamped)
            report_mismatch($sformatf("clamped got %0b expected %0b",
                                      result_if.clamped, exp_res.clamped));
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (!phase_calm && $urandom_range(0, 3) == 0) rdy_gap = pick_gap();
      end
    end
  end

  // give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (smp_fire || res_fire || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_codes.size() != 0 || smp_valid || expected_ranges.size() != 0)
      @(posedge clk_i);
  endtask

  // offset goes in only when the block is idle and any last window is done
  task automatic write_offset(int value);
    repeat (RESULT_LATENCY + 10) @(posedge clk_i);
    cfg_wdata_i <= value[tmf_pkg::OFFSET_W-1:0];
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    range_offset = value;
  endtask

  initial begin
    int                   phase_offsets [5];
    int                   value;
    logic signed [14:0]   rand_off;
    error_count  = 0;
    fill_ptr     = 0;
    range_offset = 0;
    phase_calm   = 1'b0;
    foreach (win_slots[i]) win_slots[i] = '0;
    phase_offsets = '{16383, -16384, -10000, 10000, 0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all zero window, full scale, smallest code, alternating bits,
    // then codes whose range sits just past the top of the output
    repeat (8) pending_codes.push_back(12'd0);
    repeat (8) pending_codes.push_back(12'hFFF);
    repeat (4) pending_codes.push_back(12'd1);
    pending_codes.push_back(12'h555);
    pending_codes.push_back(12'hAAA);
    pending_codes.push_back(12'd300);
    pending_codes.push_back(12'd310);
    wait_drained();

    // random phases: five fixed offsets first, the extremes among them, then random offsets
    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 5) begin
        value = phase_offsets[ph];
      end else begin
        rand_off = 15'($urandom_range(0, 32767));
        value    = int'(rand_off);
      end
      write_offset(value);
      phase_calm = (ph % 4 == 3);
      repeat (PHASE_ITEMS) pending_codes.push_back(rand_code());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_ranges.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_ranges.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
